[hdl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; clock i_clk and reset i_rst_n must be in scope at the use site
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

[hdl/jcsc_pkg.sv]
// types and constants for the jpeg coefficient symbol coder
// used by every module of the block and by its checker
package jcsc_pkg;

    localparam int C_COMPONENTS = 3;
    localparam int C_COEFF_W    = 11;
    localparam int C_ALU_W      = C_COEFF_W + 1;
    localparam int C_CAT_W      = 4;
    localparam int C_RUN_W      = 6;

    localparam logic [5:0]         C_LAST_POS  = 6'd63;
    localparam logic [C_RUN_W-1:0] C_RUN_MAX   = 6'd63;
    localparam logic [C_RUN_W-1:0] C_RUN_CHUNK = 6'd16;
    localparam logic [7:0]         C_SYM_ZRL   = 8'hF0;
    localparam logic [7:0]         C_SYM_EOB   = 8'h00;
    localparam logic [C_CAT_W-1:0] C_AC_MAX_CAT = C_CAT_W'(C_COEFF_W - 1);

    typedef struct packed {
        logic [1:0]           component;
        logic [5:0]           position;
        logic [C_COEFF_W-1:0] coefficient;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           table_select;
        logic [7:0]           symbol;
        logic [C_COEFF_W-1:0] amplitude_bits;
        logic [C_CAT_W-1:0]   amplitude_size;
        logic                 last_of_run;
    } t_out_item;

    // request to the shared adder: a + b, or a - b when sub is set
    typedef struct packed {
        logic               sub;
        logic [C_ALU_W-1:0] a;
        logic [C_ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic                 en;
        logic [1:0]           idx;
        logic [C_COEFF_W-1:0] data;
    } t_pred_wr;

endpackage

[hdl/jpeg_coefficient_symbol_coder.sv]
// Steps: a dc item passes diff, mag, amp and out before its result loads, a nonzero ac item
// mag, amp, one zrl step per zrl symbol, and out; a block-ending zero goes straight to out;
// other zeros give no result. The input takes one zero per cycle while idle and stalls while
// the sequencer steps one shared adder; an output register holds the last result.
// Reset (synchronous, active low) clears the dc predictors, the zero run, the sequencer
// and the output valid; no clearing pass.
module jpeg_coefficient_symbol_coder #(
    parameter int COMPONENTS = jcsc_pkg::C_COMPONENTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  jcsc_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output jcsc_pkg::t_out_item  o_out
);
    import jcsc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_AMP  = 3'd3;
    localparam logic [2:0] S_ZRL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [C_COEFF_W-1:0] CoefMin = {1'b1, {(C_COEFF_W-1){1'b0}}};
    localparam logic [C_COEFF_W-1:0] AcMin   = {1'b1, {(C_COEFF_W-2){1'b0}}, 1'b1};

    function automatic logic [C_CAT_W-1:0] bit_len(input logic [C_COEFF_W-1:0] mag);
        logic [C_CAT_W-1:0] n;
        n = '0;
        for (int i = 0; i < C_COEFF_W; i++) begin
            if (mag[i]) n = C_CAT_W'(i + 1);
        end
        return n;
    endfunction

    logic [2:0]           r_state, n_state;
    logic [1:0]           r_comp;
    logic                 r_is_dc;
    logic [C_ALU_W-1:0]   r_val;
    logic [C_COEFF_W-1:0] r_mag;
    logic [C_CAT_W-1:0]   r_cat;
    logic [C_COEFF_W-1:0] r_bits;
    logic [C_RUN_W-1:0]   r_run, n_run;
    logic                 r_out_valid;
    t_out_item            r_out;

    t_alu_req             alu_req;
    logic [C_ALU_W-1:0]   alu_sum;
    t_pred_wr             pred_wr;
    logic [C_COEFF_W-1:0] pred_rd;

    logic                 in_fire;
    logic                 comp_ok;
    logic                 out_free;
    logic                 out_load;
    logic [C_COEFF_W-1:0] ac_coef;
    logic [C_CAT_W-1:0]   amp_cat;
    logic [C_ALU_W-1:0]   amp_mask;
    logic [C_RUN_W-1:0]   run_less;

    jcsc_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum)
    );

    jcsc_pred #(
        .COMPONENTS (COMPONENTS)
    ) u_pred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pred_wr),
        .i_rd_idx  (r_comp),
        .o_rd_data (pred_rd)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_fire    = i_in_valid && (r_state == S_IDLE);
    assign comp_ok    = ({1'b0, i_in.component} < 3'(COMPONENTS));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ac_coef    = (i_in.coefficient == CoefMin) ? AcMin : i_in.coefficient;
    assign amp_cat    = bit_len(r_mag);
    assign amp_mask   = (C_ALU_W'(1) << amp_cat) - C_ALU_W'(1);
    assign run_less   = alu_sum[C_RUN_W-1:0];
    assign out_load   = out_free && ((r_state == S_ZRL) || (r_state == S_OUT));

    // adder operand selection per sequencer step
    always_comb begin
        alu_req = '0;
        unique case (r_state)
            S_DIFF: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_val;
                alu_req.b   = {pred_rd[C_COEFF_W-1], pred_rd};
            end
            S_MAG: begin
                alu_req.sub = 1'b1;
                alu_req.b   = r_val;
            end
            S_AMP: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_val;
                alu_req.b   = C_ALU_W'(1);
            end
            S_ZRL: begin
                alu_req.sub = 1'b1;
                alu_req.a   = C_ALU_W'(r_run);
                alu_req.b   = C_ALU_W'(C_RUN_CHUNK);
            end
            default: alu_req = '0;
        endcase
    end

    always_comb begin
        pred_wr      = '0;
        pred_wr.en   = (r_state == S_DIFF);
        pred_wr.idx  = r_comp;
        pred_wr.data = r_val[C_COEFF_W-1:0];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_run   = r_run;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && comp_ok) begin
                    if (i_in.position == 6'd0) begin
                        n_state = S_DIFF;
                    end else if (i_in.coefficient == '0) begin
                        if (i_in.position == C_LAST_POS) begin
                            n_run   = '0;
                            n_state = S_OUT;
                        end else if (r_run != C_RUN_MAX) begin
                            n_run = r_run + C_RUN_W'(1);
                        end
                    end else begin
                        n_state = S_MAG;
                    end
                end
            end
            S_DIFF: begin
                n_run   = '0;
                n_state = S_MAG;
            end
            S_MAG: n_state = S_AMP;
            S_AMP: n_state = (r_run[C_RUN_W-1:4] != '0) ? S_ZRL : S_OUT;
            S_ZRL: begin
                if (out_free) begin
                    n_run = run_less;
                    if (run_less[C_RUN_W-1:4] == '0) n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_run   = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_comp  <= i_in.component;
            r_is_dc <= (i_in.position == 6'd0);
            r_cat   <= '0;
            r_bits  <= '0;
            if (i_in.position == 6'd0) begin
                r_val <= {i_in.coefficient[C_COEFF_W-1], i_in.coefficient};
            end else begin
                r_val <= {ac_coef[C_COEFF_W-1], ac_coef};
            end
        end
        unique case (r_state)
            S_DIFF: r_val <= alu_sum;
            S_MAG:  r_mag <= r_val[C_ALU_W-1] ? alu_sum[C_COEFF_W-1:0] : r_val[C_COEFF_W-1:0];
            S_AMP: begin
                // negative values: low category bits of value minus one
                r_cat  <= amp_cat;
                r_bits <= (r_val[C_ALU_W-1] ? alu_sum[C_COEFF_W-1:0] : r_val[C_COEFF_W-1:0])
                          & amp_mask[C_COEFF_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.table_select <= {r_comp != 2'd0, r_is_dc};
            if (r_state == S_ZRL) begin
                r_out.symbol         <= C_SYM_ZRL;
                r_out.amplitude_bits <= '0;
                r_out.amplitude_size <= '0;
                r_out.last_of_run    <= 1'b0;
            end else begin
                // eob and dc reach here with a zero run, so one form serves all
                r_out.symbol         <= {r_run[3:0], r_cat};
                r_out.amplitude_bits <= r_bits;
                r_out.amplitude_size <= r_cat;
                r_out.last_of_run    <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hdl/jcsc_alu.sv]
// shared add/subtract unit of the symbol coder
// depends on jcsc_pkg
module jcsc_alu (
    input  jcsc_pkg::t_alu_req               i_req,
    output logic [jcsc_pkg::C_ALU_W-1:0]     o_sum
);
    import jcsc_pkg::*;

    always_comb begin
        o_sum = i_req.a + (i_req.b ^ {C_ALU_W{i_req.sub}}) + C_ALU_W'(i_req.sub);
    end

endmodule

[hdl/jcsc_pred.sv]
// per-component dc predictor bank, cleared by reset
// depends on jcsc_pkg
module jcsc_pred #(
    parameter int COMPONENTS = jcsc_pkg::C_COMPONENTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  jcsc_pkg::t_pred_wr                 i_wr,
    input  logic [1:0]                         i_rd_idx,
    output logic [jcsc_pkg::C_COEFF_W-1:0]     o_rd_data
);
    import jcsc_pkg::*;

    localparam int IDX_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

    logic [C_COEFF_W-1:0] r_pred [COMPONENTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COMPONENTS; i++) begin
                r_pred[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_pred[i_wr.idx[IDX_W-1:0]] <= i_wr.data;
        end
    end

    assign o_rd_data = r_pred[i_rd_idx[IDX_W-1:0]];

endmodule

[hdl/jcsc_chk.sv]
// port checker for the jpeg coefficient symbol coder, bound to the top level
// depends on jcsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module jcsc_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input jcsc_pkg::t_out_item o_out
);
    import jcsc_pkg::*;

    logic ac_out;
    logic zrl_out;

    assign ac_out  = o_out_valid && !o_out.table_select[0];
    assign zrl_out = ac_out && (o_out.symbol == C_SYM_ZRL);

    `CHK_NEXT(a_valid_hold, o_out_valid && i_out_stall, o_out_valid)
    `CHK_NEXT(a_data_hold, o_out_valid && i_out_stall, $stable(o_out))
    `CHK_IMPL(a_ac_size, ac_out, o_out.amplitude_size <= C_AC_MAX_CAT)
    `CHK_IMPL(a_bits_fit, o_out_valid, (o_out.amplitude_bits >> o_out.amplitude_size) == '0)
    `CHK_IMPL(a_zrl_mid, zrl_out, !o_out.last_of_run && o_out.amplitude_size == '0)

endmodule

bind jpeg_coefficient_symbol_coder jcsc_chk u_chk (.*);
